/* rtl/core/bra_pkg.sv */
// Shared types, constants and helper functions for the bitmap run allocator.
// No dependencies; every other file imports this package.
`default_nettype none

package bra_pkg;

    localparam int MAX_SLOTS  = 1024;
    localparam int WORD_BITS  = 32;
    localparam int MAP_WORDS  = (MAX_SLOTS + WORD_BITS - 1) / WORD_BITS;
    localparam int SLOT_W     = $clog2(MAX_SLOTS);
    localparam int BIT_W      = $clog2(WORD_BITS);
    localparam int WADDR_W    = $clog2(MAP_WORDS);
    localparam int WCNT_W     = WADDR_W + 1;
    localparam int BCNT_W     = BIT_W + 1;
    localparam int LEN_W      = SLOT_W + 1;

    localparam logic [LEN_W-1:0] BOUND_RESET = LEN_W'(MAX_SLOTS);

    localparam logic [1:0] MODE_ALLOC = 2'd0;
    localparam logic [1:0] MODE_FREE  = 2'd1;
    localparam logic [1:0] MODE_TEST  = 2'd2;

    localparam logic [1:0] STAT_OK      = 2'd0;
    localparam logic [1:0] STAT_NO_ROOM = 2'd1;
    localparam logic [1:0] STAT_BAD_LEN = 2'd2;

    typedef logic [WORD_BITS-1:0] t_word;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_SCAN,
        ST_MARK,
        ST_SLOT_RD,
        ST_SLOT_EX,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic load;
        logic scan;
        logic mark;
        logic slot_rd;
        logic slot_ex;
        logic set_bad;
        logic set_noroom;
        logic publish;
    } t_dp_cmd;

    typedef struct packed {
        logic       len_zero;
        logic [1:0] mode;
        logic       scan_hit;
        logic       scan_end;
        logic       mark_end;
    } t_dp_stat;

    // lowest set bit, WORD_BITS when none
    function automatic logic [BCNT_W-1:0] lsb_idx(input t_word v);
        logic [BCNT_W-1:0] r;
        r = BCNT_W'(WORD_BITS);
        for (int i = WORD_BITS - 1; i >= 0; i--) begin
            if (v[i]) begin
                r = BCNT_W'(i);
            end
        end
        return r;
    endfunction

    // highest set bit, zero when none
    function automatic logic [BIT_W-1:0] msb_idx(input t_word v);
        logic [BIT_W-1:0] r;
        r = '0;
        for (int i = 0; i < WORD_BITS; i++) begin
            if (v[i]) begin
                r = BIT_W'(i);
            end
        end
        return r;
    endfunction

    // ones from bit lo to bit hi inclusive
    function automatic t_word span_mask(input logic [BIT_W-1:0] lo,
                                        input logic [BIT_W-1:0] hi);
        t_word m;
        m = ({WORD_BITS{1'b1}} << lo) & ({WORD_BITS{1'b1}} >> (BIT_W'(WORD_BITS - 1) - hi));
        return m;
    endfunction

endpackage

`default_nettype wire

/* rtl/core/bra_if.sv */
// Valid/ready channel interfaces for request and result beats.
// Depends on bra_pkg.
`default_nettype none

interface bra_req_if;
    import bra_pkg::*;
    logic                valid;
    logic                ready;
    logic [1:0]          mode;
    logic [SLOT_W-1:0]   slot_index;
    logic [LEN_W-1:0]    run_length;

    modport source (output valid, mode, slot_index, run_length, input ready);
    modport sink   (input valid, mode, slot_index, run_length, output ready);
endinterface

interface bra_rsp_if;
    import bra_pkg::*;
    logic                valid;
    logic                ready;
    logic [1:0]          status;
    logic [SLOT_W-1:0]   start_slot;
    logic                slot_used;

    modport source (output valid, status, start_slot, slot_used, input ready);
    modport sink   (input valid, status, start_slot, slot_used, output ready);
endinterface

`default_nettype wire

/* rtl/core/bra_dpath.sv */
// Datapath: bitmap memory with per-word valid bits, word-wide run search,
// run marking, slot free/test and the result registers. Depends on bra_pkg.
`default_nettype none

module bra_dpath (
    input  wire                         i_clk,
    input  wire                         i_rst_n,
    input  wire                         i_cfg_we,
    input  wire  [bra_pkg::LEN_W-1:0]   i_cfg_wdata,
    input  wire  [1:0]                  i_mode,
    input  wire  [bra_pkg::SLOT_W-1:0]  i_slot_index,
    input  wire  [bra_pkg::LEN_W-1:0]   i_run_length,
    input  wire  bra_pkg::t_dp_cmd      i_cmd,
    output bra_pkg::t_dp_stat           o_stat,
    output logic [1:0]                  o_status,
    output logic [bra_pkg::SLOT_W-1:0]  o_start_slot,
    output logic                        o_slot_used
);
    import bra_pkg::*;

    // bitmap storage
    t_word                  mem [MAP_WORDS];
    logic [MAP_WORDS-1:0]   r_wvalid;
    t_word                  r_rdata;
    logic                   r_rvalid;

    // captured request
    logic [1:0]             r_mode;
    logic [SLOT_W-1:0]      r_slot;
    logic [LEN_W-1:0]       r_len;
    logic [LEN_W-1:0]       r_bound;

    // search state
    logic [WCNT_W-1:0]      r_rd_w;
    logic                   r_dv;
    logic [WADDR_W-1:0]     r_dw;
    logic [LEN_W-1:0]       r_run;

    // marking state
    logic [WCNT_W-1:0]      r_mk_w;
    logic                   r_mk_dv;
    logic [WADDR_W-1:0]     r_mk_dw;
    logic [SLOT_W-1:0]      r_end;

    // results
    logic [1:0]             r_status;
    logic [SLOT_W-1:0]      r_start;
    logic                   r_used;
    logic [1:0]             r_o_status;
    logic [SLOT_W-1:0]      r_o_start;
    logic                   r_o_used;

    t_word                  word;
    logic [WCNT_W-1:0]      n_words;
    logic                   scan_rd;
    logic                   mark_rd;
    logic                   rd_en;
    logic [WADDR_W-1:0]     rd_addr;
    logic                   wr_en;
    logic [WADDR_W-1:0]     wr_addr;
    t_word                  wr_data;

    logic [LEN_W-1:0]       base;
    logic [LEN_W-1:0]       rem;
    t_word                  oob;
    t_word                  used_v;
    t_word                  free_v;
    t_word                  p_lvl;
    t_word                  e_acc;
    logic                   e_started;
    logic [BCNT_W-1:0]      lead_free;
    logic [LEN_W-1:0]       need;
    logic                   carry_hit;
    logic [BIT_W-1:0]       j_c;
    logic                   in_ok;
    logic                   in_hit;
    logic [BIT_W-1:0]       j_w;
    logic [BIT_W-1:0]       j_sel;
    logic                   hit;
    logic [SLOT_W-1:0]      end_c;
    logic [LEN_W-1:0]       start_sum;
    logic [SLOT_W-1:0]      start_c;
    logic [LEN_W-1:0]       n_run;
    logic [BIT_W-1:0]       mk_lo;
    logic [BIT_W-1:0]       mk_hi;
    logic [LEN_W-1:0]       bound_sum;

    assign word      = r_rvalid ? r_rdata : '0;
    assign bound_sum = r_bound + LEN_W'(WORD_BITS - 1);
    assign n_words   = bound_sum[LEN_W-1:BIT_W];

    assign scan_rd = i_cmd.scan && (r_rd_w < n_words);
    assign mark_rd = i_cmd.mark && (r_mk_w <= {1'b0, r_end[SLOT_W-1:BIT_W]});
    assign rd_en   = scan_rd || mark_rd || i_cmd.slot_rd;

    always_comb begin
        if (scan_rd) begin
            rd_addr = r_rd_w[WADDR_W-1:0];
        end else if (mark_rd) begin
            rd_addr = r_mk_w[WADDR_W-1:0];
        end else begin
            rd_addr = r_slot[SLOT_W-1:BIT_W];
        end
    end

    // word evaluation: slots at or past the bound count as used
    assign base   = {1'b0, r_dw, {BIT_W{1'b0}}};
    assign rem    = r_bound - base;
    assign oob    = (|rem[LEN_W-1:BIT_W]) ? '0 : ({WORD_BITS{1'b1}} << rem[BIT_W-1:0]);
    assign used_v = word | oob;
    assign free_v = ~used_v;

    // e_acc: bit j set when r_len free slots end at j inside this word
    always_comb begin
        p_lvl     = free_v;
        e_acc     = '1;
        e_started = 1'b0;
        for (int b = 0; b <= BIT_W; b++) begin
            if (r_len[b]) begin
                e_acc     = e_started ? (p_lvl & (e_acc << (1 << b))) : p_lvl;
                e_started = 1'b1;
            end
            p_lvl = p_lvl & (p_lvl << (1 << b));
        end
    end

    assign lead_free = lsb_idx(used_v);
    assign need      = r_len - r_run;
    assign carry_hit = need <= LEN_W'(lead_free);
    assign j_c       = BIT_W'(need - LEN_W'(1));
    assign in_ok     = (r_len[LEN_W-1:BIT_W+1] == '0);
    assign in_hit    = in_ok && (|e_acc);
    assign j_w       = BIT_W'(lsb_idx(e_acc));
    assign j_sel     = (carry_hit && !(in_hit && (j_w < j_c))) ? j_c : j_w;
    assign hit       = i_cmd.scan && r_dv && (carry_hit || in_hit);
    assign end_c     = {r_dw, j_sel};
    assign start_sum = {1'b0, end_c} + LEN_W'(1) - r_len;
    assign start_c   = start_sum[SLOT_W-1:0];
    assign n_run     = (used_v == '0) ? (r_run + LEN_W'(WORD_BITS))
                                      : LEN_W'(BIT_W'(WORD_BITS - 1) - msb_idx(used_v));

    assign mk_lo = (r_mk_dw == r_start[SLOT_W-1:BIT_W]) ? r_start[BIT_W-1:0] : '0;
    assign mk_hi = (r_mk_dw == r_end[SLOT_W-1:BIT_W]) ? r_end[BIT_W-1:0]
                                                      : BIT_W'(WORD_BITS - 1);

    always_comb begin
        wr_en   = 1'b0;
        wr_addr = r_mk_dw;
        wr_data = word | span_mask(mk_lo, mk_hi);
        if (r_mk_dv) begin
            wr_en = 1'b1;
        end else if (i_cmd.slot_ex && (r_mode == MODE_FREE)) begin
            wr_en   = 1'b1;
            wr_addr = r_slot[SLOT_W-1:BIT_W];
            wr_data = word & ~(t_word'(1) << r_slot[BIT_W-1:0]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_rdata <= mem[rd_addr];
        end
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wvalid <= '0;
            r_rvalid <= 1'b0;
            r_bound  <= BOUND_RESET;
            r_dv     <= 1'b0;
            r_mk_dv  <= 1'b0;
            r_rd_w   <= '0;
            r_mk_w   <= '0;
            r_run    <= '0;
        end else begin
            if (rd_en) begin
                r_rvalid <= r_wvalid[rd_addr];
            end
            if (wr_en) begin
                r_wvalid[wr_addr] <= 1'b1;
            end
            if (i_cfg_we) begin
                r_bound <= (i_cfg_wdata > BOUND_RESET) ? BOUND_RESET : i_cfg_wdata;
            end
            r_dv    <= scan_rd;
            r_mk_dv <= mark_rd;
            if (i_cmd.load) begin
                r_rd_w <= '0;
                r_run  <= '0;
            end else begin
                if (scan_rd) begin
                    r_rd_w <= r_rd_w + WCNT_W'(1);
                end
                if (i_cmd.scan && r_dv && !hit) begin
                    r_run <= n_run;
                end
            end
            if (hit) begin
                r_mk_w <= {1'b0, start_c[SLOT_W-1:BIT_W]};
            end else if (mark_rd) begin
                r_mk_w <= r_mk_w + WCNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (scan_rd) begin
            r_dw <= r_rd_w[WADDR_W-1:0];
        end
        if (mark_rd) begin
            r_mk_dw <= r_mk_w[WADDR_W-1:0];
        end
        if (i_cmd.load) begin
            r_mode   <= i_mode;
            r_slot   <= i_slot_index;
            r_len    <= i_run_length;
            r_status <= STAT_OK;
            r_start  <= '0;
            r_used   <= 1'b0;
        end
        if (hit) begin
            r_start <= start_c;
            r_end   <= end_c;
        end
        if (i_cmd.set_bad) begin
            r_status <= STAT_BAD_LEN;
        end
        if (i_cmd.set_noroom) begin
            r_status <= STAT_NO_ROOM;
        end
        if (i_cmd.slot_ex && (r_mode == MODE_TEST)) begin
            r_used <= word[r_slot[BIT_W-1:0]];
        end
        if (i_cmd.publish) begin
            r_o_status <= r_status;
            r_o_start  <= r_start;
            r_o_used   <= r_used;
        end
    end

    assign o_stat.len_zero = (r_len == '0);
    assign o_stat.mode     = r_mode;
    assign o_stat.scan_hit = hit;
    assign o_stat.scan_end = !r_dv && !(r_rd_w < n_words);
    assign o_stat.mark_end = !mark_rd && !r_mk_dv;

    assign o_status     = r_o_status;
    assign o_start_slot = r_o_start;
    assign o_slot_used  = r_o_used;

    a_no_overlap : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_dv && r_mk_dv))
        else $error("search and mark pipelines active together");

    a_dv_from_scan : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_dv |-> $past(i_cmd.scan))
        else $error("search data without a search read");

    a_run_below_len : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.scan |-> (r_run < r_len))
        else $error("carried run reached the length without a hit");

    a_mark_in_span : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_mk_dv |-> (r_mk_dw >= r_start[SLOT_W-1:BIT_W])
                 && (r_mk_dw <= r_end[SLOT_W-1:BIT_W]))
        else $error("mark write outside the allocated run");

endmodule

`default_nettype wire

/* rtl/core/bra_ctrl.sv */
// Controller state machine: sequences decode, search, mark, slot access and
// result hand-off. Depends on bra_pkg.
`default_nettype none

module bra_ctrl (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  wire                     i_in_valid,
    input  wire                     i_out_ready,
    input  wire bra_pkg::t_dp_stat  i_stat,
    output logic                    o_in_ready,
    output logic                    o_out_valid,
    output bra_pkg::t_dp_cmd        o_cmd
);
    import bra_pkg::*;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;
    logic   out_free;

    assign out_free = !r_out_valid || i_out_ready;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = ST_DECODE;
                end
            end
            ST_DECODE: begin
                unique case (i_stat.mode) inside
                    MODE_ALLOC: n_state = i_stat.len_zero ? ST_DONE : ST_SCAN;
                    MODE_FREE, MODE_TEST: n_state = ST_SLOT_RD;
                    default: n_state = ST_DONE;
                endcase
            end
            ST_SCAN: begin
                if (i_stat.scan_hit) begin
                    n_state = ST_MARK;
                end else if (i_stat.scan_end) begin
                    n_state = ST_DONE;
                end
            end
            ST_MARK: begin
                if (i_stat.mark_end) begin
                    n_state = ST_DONE;
                end
            end
            ST_SLOT_RD: n_state = ST_SLOT_EX;
            ST_SLOT_EX: n_state = ST_DONE;
            ST_DONE: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            ST_DECODE: begin
                o_cmd.set_bad = (i_stat.mode == MODE_ALLOC) && i_stat.len_zero;
            end
            ST_SCAN: begin
                o_cmd.scan       = 1'b1;
                o_cmd.set_noroom = !i_stat.scan_hit && i_stat.scan_end;
            end
            ST_MARK:    o_cmd.mark    = 1'b1;
            ST_SLOT_RD: o_cmd.slot_rd = 1'b1;
            ST_SLOT_EX: o_cmd.slot_ex = 1'b1;
            ST_DONE:    o_cmd.publish = out_free;
            default: o_cmd = '0;
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.publish) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

    a_publish_once : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.publish |=> (r_state == ST_IDLE) && r_out_valid)
        else $error("result not presented after publish");

    a_scan_exit : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAN) && i_stat.scan_hit |=> (r_state == ST_MARK))
        else $error("search hit not followed by marking");

    a_load_idle : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |-> (r_state == ST_IDLE))
        else $error("request captured outside idle");

endmodule

`default_nettype wire

/* rtl/core/bitmap_run_allocator.sv */
// First-fit bitmap run allocator top: bra_ctrl plus bra_dpath; needs bra_pkg and bra_if.
// Free/test step through slot read and slot execute; zero length or unused mode go straight
// to done; allocate searches W words (at most 32) and, on a hit, marks the S words of the run.
// One request in flight; the next is accepted the cycle after the result is published,
// also while it waits.
// Reset (sync, active low): every slot free via per-word valid bits; search bound = 1024.
`default_nettype none

module bitmap_run_allocator (
    input  wire                         i_clk,
    input  wire                         i_rst_n,
    input  wire                         i_cfg_we,
    input  wire  [bra_pkg::LEN_W-1:0]   i_cfg_wdata,
    bra_req_if.sink                     i_req,
    bra_rsp_if.source                   o_rsp
);
    import bra_pkg::*;

    t_dp_cmd  cmd;
    t_dp_stat stat;
    logic     in_ready;
    logic     out_valid;

    bra_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_req.valid),
        .i_out_ready (o_rsp.ready),
        .i_stat      (stat),
        .o_in_ready  (in_ready),
        .o_out_valid (out_valid),
        .o_cmd       (cmd)
    );

    bra_dpath u_dpath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_mode       (i_req.mode),
        .i_slot_index (i_req.slot_index),
        .i_run_length (i_req.run_length),
        .i_cmd        (cmd),
        .o_stat       (stat),
        .o_status     (o_rsp.status),
        .o_start_slot (o_rsp.start_slot),
        .o_slot_used  (o_rsp.slot_used)
    );

    assign i_req.ready = in_ready;
    assign o_rsp.valid = out_valid;

endmodule

`default_nettype wire
